// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: sv/i2cdiv_pkg.sv
package i2cdiv_pkg;

	typedef struct packed {
		logic [31:0] module_clock_hz;
		logic [31:0] requested_speed_hz;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  divider_code;
		logic [7:0]  filter_value;
		logic [31:0] achieved_speed_hz;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	localparam logic [5:0]  DEFAULT_CODE = 6'h31;
	localparam logic [15:0] DIVIDER_CAP  = 16'hFFFF;
	// (5 * (clk / 1000)) / 100000 reduces to clk / 20000000 = (clk >> 8) / 78125,
	// taken as ((clk >> 8) * FILTER_RECIP) >> FILTER_SHIFT, exact for every 32-bit clock
	localparam logic [24:0] FILTER_RECIP = 25'd28147498;
	localparam int          FILTER_SHIFT = 41;

	localparam int CAND_W = 18;

	function automatic logic [4:0] a_value(input logic [2:0] ai);
		logic [4:0] v;
		case (ai)
			3'd0:    v = 5'd10;
			3'd1:    v = 5'd12;
			3'd2:    v = 5'd14;
			3'd3:    v = 5'd16;
			3'd4:    v = 5'd18;
			3'd5:    v = 5'd20;
			3'd6:    v = 5'd24;
			default: v = 5'd30;
		endcase
		return v;
	endfunction

	// divider = B * (A + ((3 * filter) / B) * 2), B = 16 << g
	function automatic logic [CAND_W-1:0] cand_calc(input logic [2:0] ai,
			input logic [2:0] g, input logic [7:0] filt);
		logic [9:0]  tri_f;
		logic [3:0]  sh;
		logic [9:0]  quo;
		logic [6:0]  mult;
		tri_f = {2'b00, filt} + {1'b0, filt, 1'b0};
		sh    = 4'd4 + {1'b0, g};
		quo   = tri_f >> sh;
		mult  = {2'b00, a_value(ai)} + {quo[5:0], 1'b0};
		return {{(CAND_W-7){1'b0}}, mult} << sh;
	endfunction

	function automatic logic [5:0] pack_code(input logic [2:0] ai, input logic [2:0] g);
		logic [3:0] aidx;
		aidx = {1'b0, ai} + 4'd4;
		return {aidx[2], g, aidx[1:0]};
	endfunction

endpackage

// File: sv/i2cdiv_divider.sv
module i2cdiv_divider import i2cdiv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: sv/i2c_clock_divider_search.sv
// Per transfer: filter value, clock / request divide for the target divider, candidate scan,
// clock / chosen divider for the achieved speed, hand-off; both divides share one divider.
// No candidate fits: no speed divide. Zero request: no divide, no scan.
// Throughput: one item at a time; in_ready returns with out_valid once the result is loaded,
// and an output stall holds the sequencer until the output register is free.
// Reset: arst_n clears the sequencer, the divider control and the output valid at once.
`include "assert_macros.svh"

module i2c_clock_divider_search import i2cdiv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // wait for an input transfer
	localparam logic [2:0] S_FDIV = 3'd1;  // filter value from the clock, start the target divide
	localparam logic [2:0] S_TDIV = 3'd2;  // clock / request for the target divider
	localparam logic [2:0] S_SCAN = 3'd3;  // walk the 64 (A,B) candidates
	localparam logic [2:0] S_SEL  = 3'd4;  // pick final speed path
	localparam logic [2:0] S_SDIV = 3'd5;  // clock / chosen divider
	localparam logic [2:0] S_DONE = 3'd6;  // hand the result to the output register

	logic [2:0]        state_q;
	logic [31:0]       clk_q;
	logic [31:0]       req_q;
	logic [7:0]        filt_q;
	logic [15:0]       target_q;
	logic [CAND_W-1:0] best_q;
	logic [5:0]        code_q;
	logic [1:0]        status_q;
	logic [31:0]       speed_q;
	logic [5:0]        idx_q;
	logic              out_valid_q;
	out_item_t         out_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic [CAND_W-1:0] cand;
	logic              hit;
	logic [48:0]       filt_prod;
	logic [7:0]        filt_quo;
	logic [7:0]        filt_next;
	logic [15:0]       target_next;

	i2cdiv_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Accept only with the sequencer idle; results wait in the output register.
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Filter value: clock / 20 MHz by reciprocal multiplication.
	assign filt_prod = {25'd0, clk_q[31:8]} * {24'd0, FILTER_RECIP};
	assign filt_quo  = filt_prod[48:FILTER_SHIFT];

	// Raise a zero filter to 1; the largest 32-bit clock gives 214, so no saturation is needed.
	always_comb begin
		if (filt_quo == 8'd0) begin
			filt_next = 8'd1;
		end else begin
			filt_next = filt_quo;
		end
	end

	// Cap the target divider at 65535.
	assign target_next = (div_rsp.quotient > {16'd0, DIVIDER_CAP}) ? DIVIDER_CAP
		: div_rsp.quotient[15:0];

	// Candidate for the current scan index: A index in the upper bits, g in the lower.
	assign cand = cand_calc(idx_q[5:3], idx_q[2:0], filt_q);
	assign hit  = (cand > {{(CAND_W-16){1'b0}}, target_q}) && (cand < best_q);

	// Drive the shared divider from the sequencer.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = clk_q;
		div_req.divisor  = req_q;
		unique case (state_q)
			S_FDIV: begin
				div_req.start = (req_q != 32'd0);
			end
			S_SEL: begin
				div_req.start   = (status_q == ST_FOUND);
				div_req.divisor = {{(32-CAND_W){1'b0}}, best_q};
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result when the output register is free, drop it on transfer.
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					state_q <= (req_q == 32'd0) ? S_DONE : S_TDIV;
				end
				S_TDIV: begin
					if (div_rsp.done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == 6'd63) begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					state_q <= (status_q == ST_FOUND) ? S_SDIV : S_DONE;
				end
				S_SDIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold the result until the output register is free.
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				clk_q    <= in_data.module_clock_hz;
				req_q    <= in_data.requested_speed_hz;
				code_q   <= DEFAULT_CODE;
				status_q <= ST_ZERO;
				speed_q  <= in_data.requested_speed_hz;
			end
			S_FDIV: begin
				filt_q <= filt_next;
			end
			S_TDIV: begin
				if (div_rsp.done) begin
					target_q <= target_next;
					best_q   <= '1;
					status_q <= ST_NONE;
					idx_q    <= '0;
				end
			end
			S_SCAN: begin
				// Keep the earliest of equal candidates: strict less-than on best.
				if (hit) begin
					best_q   <= cand;
					code_q   <= pack_code(idx_q[5:3], idx_q[2:0]);
					status_q <= ST_FOUND;
				end
				idx_q <= idx_q + 6'd1;
			end
			S_SDIV: begin
				if (div_rsp.done) begin
					speed_q <= div_rsp.quotient;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.divider_code      <= code_q;
					out_q.filter_value      <= filt_q;
					out_q.achieved_speed_hz <= speed_q;
					out_q.status            <= status_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// The shared divider stays idle while candidates are scanned.
	`ASSERT_SAME(a_scan_div_idle, state_q == S_SCAN, !div_rsp.busy)
	// A divide finishes only in a state that waits for it.
	`ASSERT_SAME(a_done_in_wait, div_rsp.done, state_q == S_TDIV || state_q == S_SDIV)
	// A zero request reports the default code and a zero speed.
	`ASSERT_SAME(a_zero_result, out_valid && out_data.status == ST_ZERO,
		out_data.divider_code == DEFAULT_CODE && out_data.achieved_speed_hz == 32'd0)
	// Every input transfer moves to the filter step with the divider free.
	`ASSERT_NEXT(a_start_div, in_valid && in_ready, !div_rsp.busy && state_q == S_FDIV)

endmodule

// File: dv/i2c_clock_divider_search_tb.sv
`timescale 1ns / 100ps

module i2c_clock_divider_search_tb;
	import i2cdiv_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1230;
	// Idle margin after the last result, so a stray result transfer is still caught.
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Rotate the idling mode every this many accepted requests.
	localparam int PHASE_LEN    = 150;
	localparam int MAX_REPORTS  = 10;

	// Prescaler A values, lowest index first, five bits each.
	localparam logic [39:0] A_TABLE = {5'd30, 5'd24, 5'd20, 5'd18, 5'd16, 5'd14, 5'd12, 5'd10};

	typedef enum logic [1:0] {
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} idle_phase_e;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Requests waiting to be driven, and divider settings predicted for accepted requests.
	in_item_t    fdr_requests[$];
	out_item_t   fdr_expected[$];
	int          accepted_requests = 0;
	int          mismatches        = 0;
	int          cycle_count       = 0;
	idle_phase_e idle_phase;
	out_item_t   want;

	i2c_clock_divider_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predict the divider code, filter, achieved speed and status for one request.
	function automatic out_item_t compute_fdr(input in_item_t req);
		out_item_t   res;
		logic [31:0] clk_hz;
		logic [31:0] filt;
		logic [31:0] target;
		logic [31:0] best;
		logic [31:0] cand;
		logic [31:0] b_val;
		logic [31:0] a_val;
		logic [3:0]  a_idx;
		clk_hz = req.module_clock_hz;
		// Filter rate from the clock in kHz; clamp to 1..255.
		filt = (32'd5 * (clk_hz / 32'd1000)) / 32'd100000;
		if (filt == 32'd0)
			filt = 32'd1;
		if (filt > 32'd255)
			filt = 32'd255;
		res.divider_code      = DEFAULT_CODE;
		res.filter_value      = filt[7:0];
		res.achieved_speed_hz = req.requested_speed_hz;
		if (req.requested_speed_hz == 32'd0) begin
			// Zero request: skip the division and the search entirely.
			res.status = ST_ZERO;
		end else begin
			target = clk_hz / req.requested_speed_hz;
			if (target > {16'd0, DIVIDER_CAP})
				target = {16'd0, DIVIDER_CAP};
			best       = '1;
			res.status = ST_NONE;
			// A outer, B inner; strict compares keep the earliest on a tie.
			for (int ai = 0; ai < 8; ai++) begin
				a_val = {27'd0, A_TABLE[ai*5 +: 5]};
				a_idx = 4'(ai + 4);
				for (int g = 0; g < 8; g++) begin
					b_val = 32'd16 << g;
					cand  = b_val * (a_val + ((32'd3 * filt) / b_val) * 32'd2);
					if (cand > target && cand < best) begin
						best                  = cand;
						res.divider_code      = {a_idx[2], 3'(g), a_idx[1:0]};
						res.achieved_speed_hz = clk_hz / cand;
						res.status            = ST_FOUND;
					end
				end
			end
		end
		return res;
	endfunction

	function automatic bit percent(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit sender_idles(input idle_phase_e ph);
		case (ph)
			PH_SEND_IDLE: return percent(86);
			PH_BOTH:      return percent(19);
			default:      return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls(input idle_phase_e ph);
		case (ph)
			PH_RECV_STALL: return percent(86);
			PH_BOTH:       return percent(19);
			default:       return 1'b0;
		endcase
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic add_request(input logic [31:0] clk_hz, input logic [31:0] speed_hz);
		in_item_t item;
		item.module_clock_hz    = clk_hz;
		item.requested_speed_hz = speed_hz;
		fdr_requests.push_back(item);
	endtask

	assign idle_phase = idle_phase_e'((accepted_requests / PHASE_LEN) % 4);

	// Driver: hold the request until it transfers, then load the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				fdr_expected.push_back(compute_fdr(in_data));
				accepted_requests++;
			end
			// Only advance once the current request has gone, or if nothing is up.
			if (!in_valid || in_ready) begin
				if (fdr_requests.size() != 0 && !sender_idles(idle_phase)) begin
					in_valid <= 1'b1;
					in_data  <= fdr_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (fdr_expected.size() == 0) begin
					note_failure($sformatf("result with nothing pending: code=%h filt=%0d spd=%0d st=%0d",
						out_data.divider_code, out_data.filter_value,
						out_data.achieved_speed_hz, out_data.status));
				end else begin
					want = fdr_expected.pop_front();
					if (out_data.divider_code !== want.divider_code ||
							out_data.filter_value !== want.filter_value ||
							out_data.achieved_speed_hz !== want.achieved_speed_hz ||
							out_data.status !== want.status)
						note_failure($sformatf({"mismatch: exp code=%h filt=%0d spd=%0d st=%0d,",
							" got code=%h filt=%0d spd=%0d st=%0d"},
							want.divider_code, want.filter_value, want.achieved_speed_hz,
							want.status, out_data.divider_code, out_data.filter_value,
							out_data.achieved_speed_hz, out_data.status));
				end
			end
			out_ready <= !receiver_stalls(idle_phase);
		end
	end

	// Watchdog: drop out if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [31:0] clk_hz;
		logic [31:0] speed_hz;

		// Directed requests: zero requests, capped and zero targets, filter clamp edges,
		// the largest candidate boundary, exact hits on a candidate, bit patterns.
		add_request(32'd0, 32'd0);
		add_request(32'hFFFF_FFFF, 32'd0);
		add_request(32'hFFFF_FFFF, 32'd1);
		add_request(32'd0, 32'd1);
		add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(32'd1, 32'hFFFF_FFFF);
		add_request(32'd19_999_999, 32'd100_000);
		add_request(32'd20_000_000, 32'd100_000);
		add_request(32'd66_000_000, 32'd100_000);
		add_request(32'd100_000_000, 32'd400_000);
		add_request(32'd400_000_000, 32'd100);
		add_request(32'd61_440_000, 32'd1000);
		add_request(32'd61_439_000, 32'd1000);
		add_request(32'd160, 32'd1);
		add_request(32'd100, 32'd1);
		add_request(32'd1000, 32'd2000);
		add_request(32'h8000_0000, 32'h0000_8000);
		add_request(32'h5555_5555, 32'h0000_AAAA);
		add_request(32'hAAAA_AAAA, 32'h0000_5555);
		add_request(32'd50_000_000, 32'd1000);
		add_request(32'd333_333_333, 32'd3_400_000);

		// Random requests, mostly aimed so the target lands inside the candidate range.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					clk_hz   = $urandom();
					speed_hz = clk_hz / $urandom_range(1, 70000);
				end
				4, 5: begin
					clk_hz   = $urandom_range(1_000_000, 500_000_000);
					speed_hz = $urandom_range(1000, 5_000_000);
				end
				6, 7: begin
					clk_hz   = $urandom();
					speed_hz = $urandom();
				end
				8: begin
					clk_hz   = $urandom();
					speed_hz = 32'd0;
				end
				default: begin
					clk_hz   = $urandom_range(0, 20_000_000);
					speed_hz = $urandom_range(1, 2000);
				end
			endcase
			add_request(clk_hz, speed_hz);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request has transferred and every result has come back.
		while (fdr_requests.size() != 0 || in_valid || fdr_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && fdr_expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
